// File: hdl/ttlc_pkg.sv
// ---------------------------------------------------------------------------
// ttlc_pkg
// Shared types, codes and helpers for the expiry-ordered TTL cache.
// ---------------------------------------------------------------------------
package ttlc_pkg;

  localparam int MaxEntries = 32;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int CapW       = 6;
  localparam int WordW      = 32;
  localparam int CfgIdxW    = 1;
  localparam int EvcW       = 6;

  localparam logic [CfgIdxW-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIFETIME = 1'd1;

  localparam logic [CapW-1:0]  CAP_RESET  = 6'd20;
  localparam logic [WordW-1:0] LIFE_RESET = 32'd600000;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [2:0] ST_MISS    = 3'd0;
  localparam logic [2:0] ST_HIT     = 3'd1;
  localparam logic [2:0] ST_REFRESH = 3'd2;
  localparam logic [2:0] ST_INSERT  = 3'd3;
  localparam logic [2:0] ST_TICK    = 3'd4;

  typedef struct packed {
    logic [WordW-1:0] key;
    logic [WordW-1:0] handle;
    logic [WordW-1:0] expiry;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic       start;
    logic       tick;
    logic       search;
    logic       take_data;
    logic       bubble;
    logic       drop_rd;
    logic       drop;
    logic       append;
    logic       set_status;
    logic [2:0] code;
    logic       out_load;
  } ttlc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic miss;
    logic bub_done;
    logic expired;
    logic full;
  } ttlc_sts_t;

  function automatic logic [WordW-1:0] sat_add(input logic [WordW-1:0] a,
                                               input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW] ? '1 : s[WordW-1:0];
  endfunction

endpackage

// File: hdl/ttlc_dp.sv
// ---------------------------------------------------------------------------
// ttlc_dp
// Datapath: entry memory kept as a ring (head pointer plus count), time,
// config registers, carried entry for the bubble pass and result registers.
// ---------------------------------------------------------------------------
module ttlc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttlc_pkg::ttlc_cmd_t           cmd_i,
  output ttlc_pkg::ttlc_sts_t           sts_o,
  input  logic [ttlc_pkg::WordW-1:0]    key_i,
  input  logic [ttlc_pkg::WordW-1:0]    data_handle_i,
  input  logic                          cfg_we_i,
  input  logic [ttlc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttlc_pkg::WordW-1:0]    cfg_data_i,
  output logic [2:0]                    status_o,
  output logic [ttlc_pkg::WordW-1:0]    data_out_o,
  output logic [ttlc_pkg::EvcW-1:0]     evicted_count_o
);

  ttlc_pkg::entry_t mem [ttlc_pkg::MaxEntries];

  logic [ttlc_pkg::IdxW-1:0]  head_q;
  logic [ttlc_pkg::CntW-1:0]  count_q, idx_q, cur_q, cap_eff;
  logic [ttlc_pkg::CapW-1:0]  cap_q;
  logic [ttlc_pkg::WordW-1:0] life_q, time_q, key_q, hdl_q, res_data_q;
  logic [ttlc_pkg::EvcW-1:0]  evict_q;
  logic [2:0]                 res_status_q;
  logic                       rdv_q;
  ttlc_pkg::entry_t           rd_q, car_q, wd;
  logic [ttlc_pkg::IdxW-1:0]  ra, wa;
  logic                       we, swap;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = ttlc_pkg::CntW'(1);
    end else if (int'(cap_q) > ttlc_pkg::MaxEntries) begin
      cap_eff = ttlc_pkg::CntW'(ttlc_pkg::MaxEntries);
    end else begin
      cap_eff = ttlc_pkg::CntW'(cap_q);
    end
  end

  // next entry moves ahead of the carried one when it expires earlier
  assign swap = rdv_q && (rd_q.expiry < car_q.expiry);

  assign sts_o.hit      = rdv_q && (rd_q.key == key_q);
  assign sts_o.miss     = !rdv_q && (idx_q >= count_q);
  assign sts_o.bub_done = !rdv_q;
  assign sts_o.expired  = (count_q != '0) && (rd_q.expiry < time_q);
  assign sts_o.full     = count_q >= cap_eff;

  assign ra = cmd_i.drop_rd ? head_q : head_q + idx_q[ttlc_pkg::IdxW-1:0];

  always_comb begin
    we = 1'b0;
    wa = head_q + cur_q[ttlc_pkg::IdxW-1:0];
    wd = swap ? rd_q : car_q;
    if (cmd_i.bubble) begin
      we = 1'b1;
    end else if (cmd_i.append && (int'(count_q) < ttlc_pkg::MaxEntries)) begin
      we        = 1'b1;
      wa        = head_q + count_q[ttlc_pkg::IdxW-1:0];
      wd.key    = key_q;
      wd.handle = hdl_q;
      wd.expiry = ttlc_pkg::sat_add(time_q, life_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      time_q  <= '0;
      cap_q   <= ttlc_pkg::CAP_RESET;
      life_q  <= ttlc_pkg::LIFE_RESET;
      rdv_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ttlc_pkg::CFG_CAPACITY: cap_q  <= cfg_data_i[ttlc_pkg::CapW-1:0];
          ttlc_pkg::CFG_LIFETIME: life_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.tick && (time_q != '1)) begin
        time_q <= time_q + 1'b1;
      end
      if (cmd_i.start) begin
        idx_q <= '0;
        rdv_q <= 1'b0;
      end else if (cmd_i.search || cmd_i.bubble) begin
        rdv_q <= idx_q < count_q;
        if (idx_q < count_q) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (cmd_i.drop) begin
        head_q  <= head_q + 1'b1;
        count_q <= count_q - 1'b1;
      end else if (cmd_i.append && (int'(count_q) < ttlc_pkg::MaxEntries)) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q        <= key_i;
      hdl_q        <= data_handle_i;
      res_status_q <= cmd_i.set_status ? cmd_i.code : ttlc_pkg::ST_MISS;
      res_data_q   <= '0;
      evict_q      <= '0;
    end else begin
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.code;
      end
      if (cmd_i.drop && (evict_q != '1)) begin
        evict_q <= evict_q + 1'b1;
      end
    end
    // hit: idx_q already points one past the matching entry
    if (cmd_i.search && sts_o.hit) begin
      car_q.key    <= rd_q.key;
      car_q.handle <= rd_q.handle;
      car_q.expiry <= ttlc_pkg::sat_add(rd_q.expiry, life_q);
      cur_q        <= idx_q - 1'b1;
      if (cmd_i.take_data) begin
        res_data_q <= rd_q.handle;
      end
    end else if (cmd_i.bubble && rdv_q) begin
      cur_q <= cur_q + 1'b1;
      if (!swap) begin
        car_q <= rd_q;
      end
    end
    if (cmd_i.out_load) begin
      status_o        <= res_status_q;
      data_out_o      <= res_data_q;
      evicted_count_o <= evict_q;
    end
  end

endmodule

// File: hdl/ttlc_ctrl.sv
// ---------------------------------------------------------------------------
// ttlc_ctrl
// Sequencer: key search, bubble pass, front drops, append, result handoff.
// ---------------------------------------------------------------------------
module ttlc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ttlc_pkg::ttlc_cmd_t cmd_o,
  input  ttlc_pkg::ttlc_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_BUBBLE,
    S_DROP_RD,
    S_DROP_CHK,
    S_APPEND,
    S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] op_q;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          case (command_i)
            ttlc_pkg::CMD_LOOKUP, ttlc_pkg::CMD_INSERT: state_d = S_SEARCH;
            ttlc_pkg::CMD_TICK: begin
              cmd_o.tick = 1'b1;
              state_d    = S_FIN;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_SEARCH: begin
        cmd_o.search    = 1'b1;
        cmd_o.take_data = op_q == ttlc_pkg::CMD_LOOKUP;
        if (sts_i.hit) begin
          cmd_o.set_status = 1'b1;
          cmd_o.code       = (op_q == ttlc_pkg::CMD_LOOKUP) ? ttlc_pkg::ST_HIT
                                                            : ttlc_pkg::ST_REFRESH;
          state_d          = S_BUBBLE;
        end else if (sts_i.miss) begin
          if (op_q != ttlc_pkg::CMD_INSERT) begin
            state_d = S_FIN;
          end else if (sts_i.full) begin
            state_d = S_DROP_RD;
          end else begin
            state_d = S_APPEND;
          end
        end
      end
      S_BUBBLE: begin
        cmd_o.bubble = 1'b1;
        if (sts_i.bub_done) begin
          state_d = S_FIN;
        end
      end
      S_DROP_RD: begin
        cmd_o.drop_rd = 1'b1;
        state_d       = S_DROP_CHK;
      end
      S_DROP_CHK: begin
        if (sts_i.expired) begin
          cmd_o.drop = 1'b1;
          state_d    = S_DROP_RD;
        end else begin
          cmd_o.drop = sts_i.full;
          state_d    = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd_o.append     = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.code       = ttlc_pkg::ST_INSERT;
        state_d          = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (accept && (command_i == ttlc_pkg::CMD_TICK)) begin
      cmd_o.set_status = 1'b1;
      cmd_o.code       = ttlc_pkg::ST_TICK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= ttlc_pkg::CMD_LOOKUP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        op_q <= command_i;
      end
    end
  end

endmodule

// File: hdl/expiry_ordered_ttl_cache_core.sv
// ---------------------------------------------------------------------------
// expiry_ordered_ttl_cache_core
// Keyed TTL cache over a 32-entry ring memory, one request at a time.
// ---------------------------------------------------------------------------
// A lookup or insert first searches the entries for the key; a hit refreshes the entry's
// expiry and bubbles it back into expiry order, and an insert miss appends, after first
// checking front entries for eviction when the table is full. Tick and unused commands
// go straight to the result hand off.
// One request at a time: the next is taken once the result sits in the output register.
// Reset empties the cache, zeroes time, sets capacity 20 and lifetime 600000.
module expiry_ordered_ttl_cache_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [ttlc_pkg::WordW-1:0]    key_i,
  input  logic [ttlc_pkg::WordW-1:0]    data_handle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [ttlc_pkg::WordW-1:0]    data_out_o,
  output logic [ttlc_pkg::EvcW-1:0]     evicted_count_o,
  input  logic                          cfg_we_i,
  input  logic [ttlc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttlc_pkg::WordW-1:0]    cfg_data_i
);

  ttlc_pkg::ttlc_cmd_t cmd;
  ttlc_pkg::ttlc_sts_t sts;

  ttlc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ttlc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .key_i           (key_i),
    .data_handle_i   (data_handle_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .status_o        (status_o),
    .data_out_o      (data_out_o),
    .evicted_count_o (evicted_count_o)
  );

  // one request in flight: taking a request closes the input next cycle
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while busy");

  // evictions are reported only by an insert
  a_evict_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (evicted_count_o != '0)) |-> (status_o == ttlc_pkg::ST_INSERT))
    else $error("eviction count on non-insert result");

  // handle is returned only on a lookup hit
  a_data_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ttlc_pkg::ST_HIT)) |-> (data_out_o == '0))
    else $error("data returned without a hit");

endmodule
